@@ hw/rtl/dsph_pkg.sv @@
package dsph_pkg;

    // Step limit of the arctangent table and minimum root steps
    localparam int MAX_STEPS  = 24;
    localparam int ROOT_STEPS = 16;

    // Datapath widths: coordinates carry the axis scaled by 2^8, angles are 2^-16 rad
    localparam int CW = 28;
    localparam int ZW = 22;

    localparam logic signed [ZW-1:0] Q16_HALF_PI = 22'sd102944;
    localparam logic signed [ZW-1:0] Q16_PI      = 22'sd205887;
    localparam logic signed [ZW-1:0] Q16_TWO_PI  = 22'sd411775;
    localparam logic signed [18:0]   Q13_HALF_PI = 19'sd12868;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 28'sd5094007;

    // Register index, taken from paddr[2]
    localparam logic REG_DEADZONE = 1'b0;

    localparam logic [14:0] DEADZONE_RESET = 15'd3277;

    typedef struct packed {
        logic load;
        logic step;
        logic vec;
    } t_cordic_cmd;

    typedef struct packed {
        logic load_in;
        logic sel_right;
        logic vec_load;
        logic sq_y;
        logic sq_sum;
        logic vec_iter;
        logic vec_fin;
        logic rot_load;
        logic rot_wrap;
        logic rot_fold;
        logic rot_iter;
        logic rot_fin;
    } t_cmd;

    function automatic logic [15:0] atan_q16(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30385;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/dsph_isqrt.sv @@
module dsph_isqrt (
    input  logic        i_clk,
    input  logic        i_start,
    input  logic        i_step,
    input  logic [31:0] i_n,
    output logic [15:0] o_root
);

    logic [31:0] r_rem;
    logic [31:0] r_root;
    logic [31:0] r_bit;
    logic [32:0] w_trial;
    logic [31:0] w_round;

    assign w_trial = {1'b0, r_root} + {1'b0, r_bit};

    // one result bit per step; idle once the probe bit has shifted out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_n;
            r_root <= '0;
            r_bit  <= 32'h4000_0000;
        end else if (i_step && (r_bit != '0)) begin
            if ({1'b0, r_rem} >= w_trial) begin
                r_rem  <= r_rem - w_trial[31:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // round to nearest: bump when the remainder exceeds the root
    assign w_round = r_root + ((r_rem > r_root) ? 32'd1 : 32'd0);
    assign o_root  = w_round[15:0];

endmodule

@@ hw/rtl/dsph_cordic.sv @@
module dsph_cordic #(
    parameter int CNT_W = 5
) (
    input  logic                             i_clk,
    input  dsph_pkg::t_cordic_cmd            i_cmd,
    input  logic [CNT_W-1:0]                 i_idx,
    input  logic signed [dsph_pkg::CW-1:0]   i_x,
    input  logic signed [dsph_pkg::CW-1:0]   i_y,
    input  logic signed [dsph_pkg::ZW-1:0]   i_z,
    output logic signed [dsph_pkg::CW-1:0]   o_x,
    output logic signed [dsph_pkg::CW-1:0]   o_y,
    output logic signed [dsph_pkg::ZW-1:0]   o_z
);

    logic signed [dsph_pkg::CW-1:0] r_x;
    logic signed [dsph_pkg::CW-1:0] r_y;
    logic signed [dsph_pkg::ZW-1:0] r_z;
    logic signed [dsph_pkg::CW-1:0] w_dx;
    logic signed [dsph_pkg::CW-1:0] w_dy;
    logic signed [dsph_pkg::ZW-1:0] w_at;
    logic                           w_up;

    assign w_dx = r_y >>> i_idx;
    assign w_dy = r_x >>> i_idx;
    assign w_at = $signed(dsph_pkg::ZW'(dsph_pkg::atan_q16(5'(i_idx))));

    // vectoring drives y towards zero, rotation drives z towards zero
    assign w_up = i_cmd.vec ? !r_y[dsph_pkg::CW-1] : r_z[dsph_pkg::ZW-1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
        end else if (i_cmd.step) begin
            if (w_up) begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end else begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

@@ hw/rtl/dsph_dp.sv @@
module dsph_dp #(
    parameter int STEPS = 16,
    parameter int ITERS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dsph_pkg::t_cmd             i_cmd,
    input  logic [$clog2(ITERS)-1:0]   i_cnt,
    input  logic [14:0]                i_deadzone,
    input  logic signed [15:0]         i_left_x,
    input  logic signed [15:0]         i_left_y,
    input  logic signed [15:0]         i_right_x,
    input  logic signed [15:0]         i_right_y,
    input  logic signed [15:0]         i_camera_yaw,
    output logic [15:0]                o_left_speed,
    output logic signed [16:0]         o_left_angle,
    output logic [15:0]                o_right_speed,
    output logic signed [16:0]         o_right_angle,
    output logic signed [15:0]         o_heading_x,
    output logic signed [15:0]         o_heading_y
);

    localparam int CNT_W = $clog2(ITERS);
    localparam int CW    = dsph_pkg::CW;
    localparam int ZW    = dsph_pkg::ZW;

    function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
        logic signed [15:0] r;
        if (v > 21'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -21'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    logic signed [15:0] r_lx, r_ly, r_rx, r_ry, r_yaw;
    logic signed [15:0] w_sx, w_sy;
    logic [16:0]        w_ax, w_ay;
    logic               r_active, r_zero_ang, r_flip;
    logic signed [15:0] w_op;
    logic signed [31:0] w_sq;
    logic [30:0]        r_prod;
    logic [31:0]        r_sum;
    logic [31:0]        w_n;
    logic [15:0]        w_root;

    logic signed [16:0] r_held_l, r_held_r;
    logic [15:0]        r_speed_l, r_speed_r;

    dsph_pkg::t_cordic_cmd   w_ccmd;
    logic signed [CW-1:0]    w_x0, w_y0, w_cx, w_cy;
    logic signed [ZW-1:0]    w_z0, w_cz;
    logic signed [CW-1:0]    w_sx_s, w_sy_s;
    logic signed [17:0]      w_diff;
    logic signed [ZW-1:0]    w_zwrap, w_zfold;
    logic                    w_fold;
    logic signed [ZW-1:0]    w_zr;
    logic signed [18:0]      w_a19, w_ang;
    logic signed [CW-1:0]    w_xr_full, w_yr_full;
    logic signed [20:0]      w_xr, w_yr, w_c, w_s;

    // stick under work
    assign w_sx = i_cmd.sel_right ? r_rx : r_lx;
    assign w_sy = i_cmd.sel_right ? r_ry : r_ly;

    assign w_ax = w_sx[15] ? (17'd0 - {1'b1, w_sx}) : {1'b0, w_sx};
    assign w_ay = w_sy[15] ? (17'd0 - {1'b1, w_sy}) : {1'b0, w_sy};

    // squares through one shared multiplier: x first, then y
    assign w_op = i_cmd.sq_y ? w_sy : w_sx;
    assign w_sq = w_op * w_op;
    assign w_n  = r_sum + {1'b0, r_prod};

    dsph_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_start (i_cmd.sq_sum),
        .i_step  (i_cmd.vec_iter),
        .i_n     (w_n),
        .o_root  (w_root)
    );

    // vectoring start: fold the left half plane by a quarter turn
    assign w_sx_s = {{(CW-24){w_sx[15]}}, w_sx, 8'd0};
    assign w_sy_s = {{(CW-24){w_sy[15]}}, w_sy, 8'd0};

    // rotation start: held left angle minus yaw, to 2^-16 rad
    assign w_diff = {r_held_l[16], r_held_l} - {{2{r_yaw[15]}}, r_yaw};

    always_comb begin
        w_zwrap = w_cz;
        if (w_cz > dsph_pkg::Q16_PI) begin
            w_zwrap = w_cz - dsph_pkg::Q16_TWO_PI;
        end else if (w_cz < -dsph_pkg::Q16_PI) begin
            w_zwrap = w_cz + dsph_pkg::Q16_TWO_PI;
        end
    end

    always_comb begin
        w_zfold = w_cz;
        w_fold  = 1'b0;
        if (w_cz > dsph_pkg::Q16_HALF_PI) begin
            w_zfold = w_cz - dsph_pkg::Q16_PI;
            w_fold  = 1'b1;
        end else if (w_cz < -dsph_pkg::Q16_HALF_PI) begin
            w_zfold = w_cz + dsph_pkg::Q16_PI;
            w_fold  = 1'b1;
        end
    end

    always_comb begin
        w_x0 = dsph_pkg::CORDIC_GAIN;
        w_y0 = '0;
        w_z0 = '0;
        if (i_cmd.vec_load) begin
            if (w_sx[15]) begin
                if (!w_sy[15]) begin
                    w_x0 = w_sy_s;
                    w_y0 = w_sx_s;
                    w_z0 = -dsph_pkg::Q16_HALF_PI;
                end else begin
                    w_x0 = -w_sy_s;
                    w_y0 = -w_sx_s;
                    w_z0 = dsph_pkg::Q16_HALF_PI;
                end
            end else begin
                w_x0 = w_sx_s;
                w_y0 = -w_sy_s;
            end
        end else if (i_cmd.rot_load) begin
            w_z0 = {{(ZW-21){w_diff[17]}}, w_diff, 3'b000};
        end else if (i_cmd.rot_wrap) begin
            w_z0 = w_zwrap;
        end else begin
            w_z0 = w_zfold;
        end
    end

    assign w_ccmd.load = i_cmd.vec_load | i_cmd.rot_load | i_cmd.rot_wrap | i_cmd.rot_fold;
    assign w_ccmd.step = (i_cmd.vec_iter && ({1'b0, i_cnt} < (CNT_W+1)'(STEPS)))
                         || i_cmd.rot_iter;
    assign w_ccmd.vec  = i_cmd.vec_iter;

    dsph_cordic #(
        .CNT_W (CNT_W)
    ) u_cordic (
        .i_clk (i_clk),
        .i_cmd (w_ccmd),
        .i_idx (i_cnt),
        .i_x   (w_x0),
        .i_y   (w_y0),
        .i_z   (w_z0),
        .o_x   (w_cx),
        .o_y   (w_cy),
        .o_z   (w_cz)
    );

    // angle to Q3.13 with rounding, then the quarter turn unless exactly zero
    assign w_zr  = w_cz + ZW'(4);
    assign w_a19 = 19'(w_zr >>> 3);
    assign w_ang = r_zero_ang ? 19'sd0
                 : ((w_a19 != 19'sd0) ? (w_a19 - dsph_pkg::Q13_HALF_PI) : w_a19);

    // sine and cosine to Q1.15 with rounding, undo the half-turn fold
    assign w_xr_full = (w_cx + CW'(128)) >>> 8;
    assign w_yr_full = (w_cy + CW'(128)) >>> 8;
    assign w_xr      = w_xr_full[20:0];
    assign w_yr      = w_yr_full[20:0];
    assign w_c       = r_flip ? -w_xr : w_xr;
    assign w_s       = r_flip ? w_yr : -w_yr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_lx  <= i_left_x;
            r_ly  <= i_left_y;
            r_rx  <= i_right_x;
            r_ry  <= i_right_y;
            r_yaw <= i_camera_yaw;
        end
        if (i_cmd.vec_load) begin
            r_active   <= (w_ax > {2'b00, i_deadzone}) || (w_ay > {2'b00, i_deadzone});
            r_zero_ang <= (w_sy == 16'sd0) && !w_sx[15] && (w_sx != 16'sd0);
        end
        if (i_cmd.vec_load || i_cmd.sq_y) begin
            r_prod <= w_sq[30:0];
        end
        if (i_cmd.sq_y) begin
            r_sum <= {1'b0, r_prod};
        end
        if (i_cmd.rot_fold) begin
            r_flip <= w_fold;
        end
        if (i_cmd.vec_fin) begin
            if (i_cmd.sel_right) begin
                r_speed_r <= r_active ? w_root : 16'd0;
            end else begin
                r_speed_l <= r_active ? w_root : 16'd0;
            end
        end
        if (i_cmd.rot_fin) begin
            o_left_speed  <= r_speed_l;
            o_left_angle  <= r_held_l;
            o_right_speed <= r_speed_r;
            o_right_angle <= r_held_r;
            o_heading_x   <= sat16(w_c);
            o_heading_y   <= sat16(w_s);
        end
    end

    // held angles: kept while the stick rests in the deadzone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_l <= '0;
            r_held_r <= '0;
        end else if (i_cmd.vec_fin && r_active) begin
            if (i_cmd.sel_right) begin
                r_held_r <= w_ang[16:0];
            end else begin
                r_held_l <= w_ang[16:0];
            end
        end
    end

endmodule

@@ hw/rtl/dsph_ctrl.sv @@
module dsph_ctrl #(
    parameter int STEPS = 16,
    parameter int ITERS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output dsph_pkg::t_cmd            o_cmd,
    output logic [$clog2(ITERS)-1:0]  o_cnt
);

    localparam int CNT_W = $clog2(ITERS);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_V_LOAD = 11'b000_0000_0010,
        ST_V_SQY  = 11'b000_0000_0100,
        ST_V_SUM  = 11'b000_0000_1000,
        ST_V_ITER = 11'b000_0001_0000,
        ST_V_FIN  = 11'b000_0010_0000,
        ST_R_LOAD = 11'b000_0100_0000,
        ST_R_WRAP = 11'b000_1000_0000,
        ST_R_FOLD = 11'b001_0000_0000,
        ST_R_ITER = 11'b010_0000_0000,
        ST_R_FIN  = 11'b100_0000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_right, n_right;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_right     = r_right;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.sel_right = r_right;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_right       = 1'b0;
                    n_state       = ST_V_LOAD;
                end
            end
            ST_V_LOAD: begin
                o_cmd.vec_load = 1'b1;
                n_state        = ST_V_SQY;
            end
            ST_V_SQY: begin
                o_cmd.sq_y = 1'b1;
                n_state    = ST_V_SUM;
            end
            ST_V_SUM: begin
                o_cmd.sq_sum = 1'b1;
                n_cnt        = '0;
                n_state      = ST_V_ITER;
            end
            ST_V_ITER: begin
                o_cmd.vec_iter = 1'b1;
                if (r_cnt == CNT_W'(ITERS - 1)) begin
                    n_state = ST_V_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_V_FIN: begin
                o_cmd.vec_fin = 1'b1;
                if (r_right) begin
                    n_state = ST_R_LOAD;
                end else begin
                    n_right = 1'b1;
                    n_state = ST_V_LOAD;
                end
            end
            ST_R_LOAD: begin
                o_cmd.rot_load = 1'b1;
                n_state        = ST_R_WRAP;
            end
            ST_R_WRAP: begin
                o_cmd.rot_wrap = 1'b1;
                n_state        = ST_R_FOLD;
            end
            ST_R_FOLD: begin
                o_cmd.rot_fold = 1'b1;
                n_cnt          = '0;
                n_state        = ST_R_ITER;
            end
            ST_R_ITER: begin
                o_cmd.rot_iter = 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    n_state = ST_R_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_R_FIN: begin
                if (w_out_free) begin
                    o_cmd.rot_fin = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_right     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_right     <= n_right;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cnt       = r_cnt;

    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_R_FIN))
        else $error("result raised outside the final step");

    a_vec_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_V_ITER) |-> (r_cnt <= CNT_W'(ITERS - 1)))
        else $error("vectoring count overran");

    a_hold_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_R_FIN && r_out_valid && i_out_stall) |=> (r_state == ST_R_FIN))
        else $error("final step left while the result register was occupied");

    a_right_after_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_R_LOAD) |-> r_right)
        else $error("rotation started before the right stick was done");

endmodule

@@ hw/rtl/dual_stick_polar_heading.sv @@
// Dual stick polar heading. Each request carries both stick samples (Q1.15) and a camera
// yaw (Q3.13 rad) and yields exactly one result: per stick the rounded magnitude and the
// angle atan2(-y, x) less a quarter turn (zero angle stays zero), held while the stick
// sits inside the deadzone (neither axis magnitude above it), plus the heading
// (cos, -sin) of held left angle minus yaw, saturated to Q1.15. One CORDIC unit is shared:
// vectoring for the left stick, then the right stick, then rotation for the heading; a
// bit-serial square root runs alongside each vectoring pass. A new request is taken only
// while the block is idle, that is once the previous request has been through all passes
// of the shared CORDIC unit and its result is registered. The result sits in an output
// register, so a new request is taken while the previous result still waits; the next
// result is held back only if the old one is still stalled. Deadzone register at byte
// address 0 (APB, 15 bits,
// reset 3277); write it only while the block is idle.
module dual_stick_polar_heading #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_left_x,
    input  logic signed [15:0] i_left_y,
    input  logic signed [15:0] i_right_x,
    input  logic signed [15:0] i_right_y,
    input  logic signed [15:0] i_camera_yaw,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_left_speed,
    output logic signed [16:0] o_left_angle,
    output logic [15:0]        o_right_speed,
    output logic signed [16:0] o_right_angle,
    output logic signed [15:0] o_heading_x,
    output logic signed [15:0] o_heading_y,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // step count is clamped to the arctangent table; the root always needs 16 steps
    localparam int STEPS = (CORDIC_STEPS > dsph_pkg::MAX_STEPS) ? dsph_pkg::MAX_STEPS
                                                                : CORDIC_STEPS;
    localparam int ITERS = (STEPS > dsph_pkg::ROOT_STEPS) ? STEPS : dsph_pkg::ROOT_STEPS;

    dsph_pkg::t_cmd           w_cmd;
    logic [$clog2(ITERS)-1:0] w_cnt;
    logic [14:0]              r_deadzone;
    logic                     w_wr;

    // configuration: paddr[2] picks the register; anything beyond deadzone is dropped
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone <= dsph_pkg::DEADZONE_RESET;
        end else if (w_wr && (paddr[2] == dsph_pkg::REG_DEADZONE)) begin
            r_deadzone <= pwdata[14:0];
        end
    end

    assign prdata = (paddr[2] == dsph_pkg::REG_DEADZONE) ? {17'd0, r_deadzone} : 32'd0;

    // sequencer: walks left vectoring, right vectoring, heading rotation
    dsph_ctrl #(
        .STEPS (STEPS),
        .ITERS (ITERS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .o_cnt       (w_cnt)
    );

    // arithmetic: squares, root, shared CORDIC, held angles and the result register
    dsph_dp #(
        .STEPS (STEPS),
        .ITERS (ITERS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cnt         (w_cnt),
        .i_deadzone    (r_deadzone),
        .i_left_x      (i_left_x),
        .i_left_y      (i_left_y),
        .i_right_x     (i_right_x),
        .i_right_y     (i_right_y),
        .i_camera_yaw  (i_camera_yaw),
        .o_left_speed  (o_left_speed),
        .o_left_angle  (o_left_angle),
        .o_right_speed (o_right_speed),
        .o_right_angle (o_right_angle),
        .o_heading_x   (o_heading_x),
        .o_heading_y   (o_heading_y)
    );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    // Build of the block under test and the solver depth it implies
    localparam int CORDIC_STEPS = 16;
    localparam int SOLVER_STEPS = (CORDIC_STEPS > dsph_pkg::MAX_STEPS) ? dsph_pkg::MAX_STEPS
                                                                       : CORDIC_STEPS;

    // Angle constants widened for the predictor, units of 2^-16 rad
    localparam longint RAD_HALF_PI = dsph_pkg::Q16_HALF_PI;
    localparam longint RAD_PI      = dsph_pkg::Q16_PI;
    localparam longint RAD_TWO_PI  = dsph_pkg::Q16_TWO_PI;
    localparam int     QUARTER_Q13 = dsph_pkg::Q13_HALF_PI;
    localparam longint ROTOR_GAIN  = dsph_pkg::CORDIC_GAIN;

    // Register map: the deadzone at index 0, the next word is unmapped
    localparam logic [2:0] DEADZONE_ADDR = {dsph_pkg::REG_DEADZONE, 2'b00};
    localparam logic [2:0] SPARE_ADDR    = {~dsph_pkg::REG_DEADZONE, 2'b00};

    // Drain wait covers a request through the shared solver, with slack
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic signed [15:0] yaw;
    } t_stick_sample;

    typedef struct packed {
        logic [15:0]        left_speed;
        logic signed [16:0] left_angle;
        logic [15:0]        right_speed;
        logic signed [16:0] right_angle;
        logic signed [15:0] heading_x;
        logic signed [15:0] heading_y;
    } t_polar_result;

    // Clock, reset and every input of the block, known from time zero
    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic signed [15:0] left_x      = '0;
    logic signed [15:0] left_y      = '0;
    logic signed [15:0] right_x     = '0;
    logic signed [15:0] right_y     = '0;
    logic signed [15:0] camera_yaw  = '0;
    logic               out_stall   = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [2:0]         paddr       = '0;
    logic [31:0]        pwdata      = '0;

    wire                o_in_stall;
    wire                o_out_valid;
    wire [15:0]         o_left_speed;
    wire signed [16:0]  o_left_angle;
    wire [15:0]         o_right_speed;
    wire signed [16:0]  o_right_angle;
    wire signed [15:0]  o_heading_x;
    wire signed [15:0]  o_heading_y;
    wire [31:0]         prdata;
    wire                pready;

    // Predictor state: our own copy of the deadzone and the two held angles
    logic [14:0]        deadzone_q15   = dsph_pkg::DEADZONE_RESET;
    logic signed [16:0] held_left_q13  = '0;
    logic signed [16:0] held_right_q13 = '0;

    // Arctangent of 2^-i in units of 2^-16 rad
    longint atan_tab_q16 [0:23] = '{
        51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };

    t_polar_result pending_headings [$];
    t_polar_result oldest_due;

    int  errors       = 0;
    int  cycle_count  = 0;
    int  stall_left   = 0;
    int  hold_request = 0;
    bit  idle_on      = 1'b1;
    bit  result_taken = 1'b0;

    dual_stick_polar_heading #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_left_x     (left_x),
        .i_left_y     (left_y),
        .i_right_x    (right_x),
        .i_right_y    (right_y),
        .i_camera_yaw (camera_yaw),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_left_speed (o_left_speed),
        .o_left_angle (o_left_angle),
        .o_right_speed(o_right_speed),
        .o_right_angle(o_right_angle),
        .o_heading_x  (o_heading_x),
        .o_heading_y  (o_heading_y),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 20 ns period
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // Round-to-nearest integer square root of x^2 + y^2, bit by bit
    function automatic logic [15:0] rounded_magnitude(input int x, input int y);
        longint unsigned rem, root, b;
        rem  = longint'(x) * x + longint'(y) * y;
        root = 0;
        b    = 64'd1 << 32;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem  -= root + b;
                root  = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        if (rem > root) root++;
        return root[15:0];
    endfunction

    // Vectoring pass: atan2(-y, x) in Q3.13, less a quarter turn unless zero
    function automatic logic signed [16:0] vector_angle(input int x, input int y);
        longint cx, cy, z, t, dx, dy;
        int     a, i;
        cx = longint'(x) * 256;
        cy = -(longint'(y) * 256);
        z  = 0;
        // positive x axis: exactly zero, no quarter turn
        if (y == 0 && x > 0) return '0;
        // left half plane: pre-rotate by a quarter turn; the negative x axis
        // goes clockwise so that it lands on -pi
        if (cx < 0) begin
            if (cy < 0 || y == 0) begin
                t  = -cy;
                cy = cx;
                cx = t;
                z  = -RAD_HALF_PI;
            end else begin
                t  = cy;
                cy = -cx;
                cx = t;
                z  = RAD_HALF_PI;
            end
        end
        for (i = 0; i < SOLVER_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx += dx;
                cy -= dy;
                z  += atan_tab_q16[i];
            end else begin
                cx -= dx;
                cy += dy;
                z  -= atan_tab_q16[i];
            end
        end
        a = int'((z + 4) >>> 3);
        if (a != 0) a -= QUARTER_Q13;
        return a[16:0];
    endfunction

    function automatic logic signed [15:0] clip_q15(input longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    // Rotation pass: (cos t, -sin t) for t in Q3.13
    function automatic void heading_from_angle(input int ang13,
                                               output logic signed [15:0] hx,
                                               output logic signed [15:0] hy);
        longint z, cx, cy, dx, dy;
        bit     flip;
        int     i;
        z    = longint'(ang13) * 8;
        cx   = ROTOR_GAIN;
        cy   = 0;
        flip = 1'b0;
        while (z > RAD_PI) z -= RAD_TWO_PI;
        while (z < -RAD_PI) z += RAD_TWO_PI;
        // fold the outer half circle inward and negate at the end
        if (z > RAD_HALF_PI) begin
            z    -= RAD_PI;
            flip  = 1'b1;
        end else if (z < -RAD_HALF_PI) begin
            z    += RAD_PI;
            flip  = 1'b1;
        end
        for (i = 0; i < SOLVER_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0) begin
                cx -= dx;
                cy += dy;
                z  -= atan_tab_q16[i];
            end else begin
                cx += dx;
                cy -= dy;
                z  += atan_tab_q16[i];
            end
        end
        cx = (cx + 128) >>> 8;
        cy = (cy + 128) >>> 8;
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        hx = clip_q15(cx);
        hy = clip_q15(-cy);
    endfunction

    // A stick counts once either axis magnitude exceeds the deadzone;
    // -32768 counts as 32768
    function automatic bit stick_active(input int x, input int y);
        int ax, ay;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        return (ax > int'(deadzone_q15)) || (ay > int'(deadzone_q15));
    endfunction

    // Work out the result of one request and advance the held angles
    function automatic t_polar_result compute_polar_heading(input t_stick_sample s);
        t_polar_result      r;
        logic signed [15:0] hx, hy;
        r.left_speed  = '0;
        r.right_speed = '0;
        if (stick_active(int'(s.lx), int'(s.ly))) begin
            held_left_q13 = vector_angle(int'(s.lx), int'(s.ly));
            r.left_speed  = rounded_magnitude(int'(s.lx), int'(s.ly));
        end
        if (stick_active(int'(s.rx), int'(s.ry))) begin
            held_right_q13 = vector_angle(int'(s.rx), int'(s.ry));
            r.right_speed  = rounded_magnitude(int'(s.rx), int'(s.ry));
        end
        heading_from_angle(int'(held_left_q13) - int'(s.yaw), hx, hy);
        r.left_angle  = held_left_q13;
        r.right_angle = held_right_q13;
        r.heading_x   = hx;
        r.heading_y   = hy;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall pattern at the falling edge, checking at the rising edge
    // ------------------------------------------------------------------

    // Draw a fresh hold-off after each taken result; a long hold requested by a
    // test overrides it and is counted down here
    always @(negedge clk) begin
        if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end else if (result_taken) begin
            stall_left = idle_on ? int'($urandom_range(0, 8)) : 0;
        end
        result_taken = 1'b0;
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
    end

    // Compare each taken result with the oldest outstanding prediction
    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            result_taken = 1'b1;
            if (pending_headings.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                oldest_due = pending_headings.pop_front();
                check_field("left_speed",  oldest_due.left_speed,  o_left_speed);
                check_field("left_angle",  oldest_due.left_angle,  o_left_angle);
                check_field("right_speed", oldest_due.right_speed, o_right_speed);
                check_field("right_angle", oldest_due.right_angle, o_right_angle);
                check_field("heading_x",   oldest_due.heading_x,   o_heading_x);
                check_field("heading_y",   oldest_due.heading_y,   o_heading_y);
            end
        end
    end

    // Hard stop: a hang anywhere ends the run here
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request side and configuration port
    // ------------------------------------------------------------------

    // Offer one request after a random gap, hold it until taken, then predict
    task automatic send_sample(input logic signed [15:0] lx, input logic signed [15:0] ly,
                               input logic signed [15:0] rx, input logic signed [15:0] ry,
                               input logic signed [15:0] yaw);
        t_stick_sample s;
        int            gap;
        s   = '{lx, ly, rx, ry, yaw};
        gap = idle_on ? int'($urandom_range(0, 8)) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        left_x     <= lx;
        left_y     <= ly;
        right_x    <= rx;
        right_y    <= ry;
        camera_yaw <= yaw;
        do @(posedge clk); while (o_in_stall);
        pending_headings.push_back(compute_polar_heading(s));
    endtask

    // Setup then access phase; the write lands at the edge with pready high
    task automatic apb_transfer(input bit wr, input logic [2:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        // only index 0 is mapped, and only its low 15 bits are kept
        if (wr && addr == DEADZONE_ADDR) deadzone_q15 = wdata[14:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drop valid and wait for every outstanding result
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_headings.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_deadzone(input logic [31:0] value);
        logic [31:0] rd;
        settle_block();
        apb_transfer(1'b1, DEADZONE_ADDR, value, rd);
    endtask

    function automatic logic signed [15:0] random_axis();
        int v;
        case ($urandom_range(0, 7))
            0, 1, 2: v = int'($urandom_range(0, 65535)) - 32768;
            3: begin
                // straddle the threshold
                v = int'(deadzone_q15) + int'($urandom_range(0, 4)) - 2;
                if (v < 0) v = 0;
                if (v > 32767) v = 32767;
                if ($urandom_range(0, 1) != 0) v = -v;
            end
            4: begin
                case ($urandom_range(0, 3))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = -32767;
                    default: v = 0;
                endcase
            end
            5: v = 0;
            6: v = int'($urandom_range(0, 128)) - 64;
            default: begin
                v = int'($urandom_range(24000, 32767));
                if ($urandom_range(0, 1) != 0) v = -v;
            end
        endcase
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] random_yaw();
        int v;
        if ($urandom_range(0, 7) == 0) v = ($urandom_range(0, 1) != 0) ? 25736 : -25736;
        else v = int'($urandom_range(0, 51472)) - 25736;
        return v[15:0];
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset value, an ignored write to the unmapped word, truncation of a wide write
    task automatic test_register_access();
        logic [31:0] rd;
        apb_transfer(1'b0, DEADZONE_ADDR, '0, rd);
        check_field("deadzone", deadzone_q15, rd[14:0]);
        apb_transfer(1'b1, SPARE_ADDR, 32'd5, rd);
        apb_transfer(1'b0, DEADZONE_ADDR, '0, rd);
        check_field("deadzone", deadzone_q15, rd[14:0]);
        // threshold still at its reset value: left sits on it, right just clears it
        send_sample(16'sd3277, 16'sd0, 16'sd3278, 16'sd0, 16'sd0);
        write_deadzone(32'hFFFF_FFFF);
        apb_transfer(1'b0, DEADZONE_ADDR, '0, rd);
        check_field("deadzone", deadzone_q15, rd[14:0]);
    endtask

    // At the top threshold only -32768 gets through
    task automatic test_full_scale_threshold();
        send_sample(16'sd32767, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0);
        send_sample(16'sd0, -16'sd32768, 16'sd32767, -16'sd32767, 16'sd25736);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, -16'sd25736);
    endtask

    // Either axis on or just past the threshold, then a zero threshold
    task automatic test_deadzone_edges();
        write_deadzone(dsph_pkg::DEADZONE_RESET);
        send_sample(16'sd3277, -16'sd3277, 16'sd3278, 16'sd0, 16'sd1000);
        send_sample(-16'sd3278, 16'sd3277, 16'sd0, -16'sd3278, -16'sd1000);
        send_sample(16'sd100, 16'sd3277, -16'sd3277, -16'sd3277, 16'sd0);
        write_deadzone(32'd0);
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd0);
        write_deadzone(dsph_pkg::DEADZONE_RESET);
    endtask

    // Exact zero angle, negative x axis, held angles, corners
    task automatic test_axis_special_cases();
        send_sample(16'sd20000, 16'sd0, -16'sd20000, 16'sd0, 16'sd0);
        send_sample(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 16'sd4096);
        // inside the deadzone: speeds drop to zero, angles held
        send_sample(16'sd0, 16'sd0, 16'sd100, -16'sd100, -16'sd4096);
        send_sample(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd0);
        send_sample(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd0);
        send_sample(16'sd0, 16'sd20000, 16'sd0, -16'sd20000, 16'sd0);
        send_sample(16'sd1, 16'sd1, 16'sd2, -16'sd2, 16'sd0);
    endtask

    // Unit cosine and unit negated sine saturate; yaw extremes
    task automatic test_heading_saturation();
        send_sample(16'sd30000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd30000, 16'sd0, 16'sd0, 16'sd0, 16'sd12868);
        send_sample(16'sd30000, 16'sd0, 16'sd0, 16'sd0, -16'sd12868);
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd25736);
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd25736);
    endtask

    // Hold the result side off for a long stretch while requests keep coming
    task automatic test_back_pressure();
        int n;
        idle_on      = 1'b0;
        hold_request = LONG_HOLD;
        for (n = 0; n < 12; n++)
            send_sample(random_axis(), random_axis(), random_axis(), random_axis(),
                        random_yaw());
        idle_on = 1'b1;
        settle_block();
    endtask

    // Random requests at one threshold, with stretches of no idling
    task automatic test_random_traffic(input int count, input logic [31:0] dz);
        logic signed [15:0] lx, ly, rx, ry;
        int                 n;
        write_deadzone(dz);
        for (n = 0; n < count; n++) begin
            if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
            lx = random_axis();
            ly = random_axis();
            rx = random_axis();
            ry = random_axis();
            // bias towards the horizontal axis cases
            if ($urandom_range(0, 7) == 0) ly = '0;
            if ($urandom_range(0, 7) == 0) ry = '0;
            send_sample(lx, ly, rx, ry, random_yaw());
        end
        idle_on = 1'b1;
    endtask

    initial begin
        // hold reset, then release it at a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        deadzone_q15   = dsph_pkg::DEADZONE_RESET;
        held_left_q13  = '0;
        held_right_q13 = '0;

        test_register_access();
        test_full_scale_threshold();
        test_deadzone_edges();
        test_axis_special_cases();
        test_heading_saturation();
        test_back_pressure();
        test_random_traffic(150, dsph_pkg::DEADZONE_RESET);
        test_random_traffic(80, 32'd0);
        test_random_traffic(60, 32'd32767);
        test_random_traffic(120, $urandom_range(1, 32766));
        test_random_traffic(90, 32'd12000);

        // drain, then give a stray result time to show up
        settle_block();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
